>>> hw/rtl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and constants of the ASCII integer parser: controller states,
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package aip_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned CntW   = 16;
	localparam int unsigned RdxW   = 5;
	localparam int unsigned ValW   = 64;

	localparam logic [RdxW-1:0] RDX_AUTO = 5'd0;
	localparam logic [RdxW-1:0] RDX_OCT  = 5'd8;
	localparam logic [RdxW-1:0] RDX_DEC  = 5'd10;
	localparam logic [RdxW-1:0] RDX_HEX  = 5'd16;

	localparam logic [CharW-1:0] CH_SPACE = 8'h20;
	localparam logic [CharW-1:0] CH_TAB   = 8'h09;
	localparam logic [CharW-1:0] CH_LF    = 8'h0A;
	localparam logic [CharW-1:0] CH_VT    = 8'h0B;
	localparam logic [CharW-1:0] CH_FF    = 8'h0C;
	localparam logic [CharW-1:0] CH_CR    = 8'h0D;
	localparam logic [CharW-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
	localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CH_NINE  = 8'h39;
	localparam logic [CharW-1:0] CH_UA    = 8'h41;
	localparam logic [CharW-1:0] CH_UF    = 8'h46;
	localparam logic [CharW-1:0] CH_UX    = 8'h58;
	localparam logic [CharW-1:0] CH_LA    = 8'h61;
	localparam logic [CharW-1:0] CH_LF_   = 8'h66;
	localparam logic [CharW-1:0] CH_LX    = 8'h78;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_LEAD   = 5'b00010,
		ST_PFX    = 5'b00100,
		ST_AFTER0 = 5'b01000,
		ST_DIGITS = 5'b10000
	} aip_state_t;

	// controller -> datapath
	typedef struct packed {
		logic ws;       // consume whitespace, counted in chars_used but not toward the width
		logic take;     // consume a counted character
		logic set_neg;  // minus sign seen
		logic set_any;  // a digit or prefix zero was taken
		logic rdx_oct;  // auto radix resolves to octal
		logic rdx_hex;  // 0x prefix forces hex
		logic digit;    // accumulate the decoded digit
	} aip_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_ws;
		logic is_sign;
		logic is_minus;
		logic is_zero;
		logic is_x;
		logic rdx_auto;
		logic rdx_hex;
		logic dig_ok;
		logic width_hit;
	} aip_stat_t;

	typedef struct packed {
		logic [CntW-1:0] chars_used;
		logic            this_char_taken;
		logic            matched;
		logic [ValW-1:0] parsed_value;
	} aip_res_t;

endpackage

>>> hw/rtl/aip_ctrl.sv
// ----------------------------------------------------------------------------
// aip_ctrl
// Phase state machine: decides per character what the datapath does and
// whether the conversion ends.
// ----------------------------------------------------------------------------
module aip_ctrl import aip_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      start,
	input  aip_stat_t stat,
	output aip_cmd_t  cmd,
	output logic      emit,
	output logic      taken
);

	aip_state_t state_q;
	aip_state_t state_d;
	aip_state_t cur;
	logic       reject;
	logic       go_pfx;
	logic       go_dig;

	always_comb begin
		cur     = start ? ST_LEAD : state_q;
		cmd     = '0;
		reject  = 1'b0;
		go_pfx  = 1'b0;
		go_dig  = 1'b0;
		state_d = cur;
		case (cur)
			ST_IDLE: begin
				state_d = ST_IDLE;
			end
			ST_LEAD: begin
				if (stat.is_ws) begin
					cmd.ws = 1'b1;
				end else if (stat.is_sign) begin
					cmd.take    = 1'b1;
					cmd.set_neg = stat.is_minus;
					state_d     = ST_PFX;
				end else begin
					go_pfx = 1'b1;
				end
			end
			ST_PFX: begin
				go_pfx = 1'b1;
			end
			ST_AFTER0: begin
				if (stat.is_x) begin
					cmd.rdx_hex = 1'b1;
					cmd.take    = 1'b1;
					state_d     = ST_DIGITS;
				end else begin
					go_dig = 1'b1;
				end
			end
			ST_DIGITS: begin
				go_dig = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (go_pfx) begin
			if ((stat.rdx_auto || stat.rdx_hex) && stat.is_zero) begin
				cmd.set_any = 1'b1;
				cmd.rdx_oct = stat.rdx_auto;
				cmd.take    = 1'b1;
				state_d     = ST_AFTER0;
			end else begin
				go_dig = 1'b1;
			end
		end

		if (go_dig) begin
			if (stat.dig_ok) begin
				cmd.digit   = 1'b1;
				cmd.set_any = 1'b1;
				cmd.take    = 1'b1;
				state_d     = ST_DIGITS;
			end else begin
				reject = 1'b1;
			end
		end

		emit  = reject || (cmd.take && stat.width_hit);
		taken = !reject;
		if (emit) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (en) begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/aip_dpath.sv
// ----------------------------------------------------------------------------
// aip_dpath
// Character decode, digit accumulator with saturation check, counters and
// conversion settings; forms the result fields.
// ----------------------------------------------------------------------------
module aip_dpath import aip_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             start,
	input  logic [CharW-1:0] char_in,
	input  logic [CntW-1:0]  max_width,
	input  logic [RdxW-1:0]  radix,
	input  logic             is_unsigned,
	input  aip_cmd_t         cmd,
	output aip_stat_t        stat,
	output aip_res_t         res
);

	logic [ValW-1:0] acc_q,  acc_e,  acc_n;
	logic            neg_q,  neg_e,  neg_n;
	logic            ovf_q,  ovf_e,  ovf_n;
	logic            any_q,  any_e,  any_n;
	logic [CntW-1:0] cnt_q,  cnt_e,  cnt_n,  cnt_inc;
	logic [CntW-1:0] cons_q, cons_e, cons_n;
	logic [RdxW-1:0] rdx_q,  rdx_e,  rdx_n,  rdx_dig;
	logic [CntW-1:0] wl_q,   wl_e;
	logic            uns_q,  uns_e;

	logic [3:0]      dig;
	logic            dig_vld;
	logic [68:0]     prod;
	logic [69:0]     sum;
	logic [69:0]     lim;
	logic            ovf_now;
	logic [ValW-1:0] smax;

	// Start discards the running conversion and samples new settings
	always_comb begin
		acc_e  = start ? '0 : acc_q;
		neg_e  = start ? 1'b0 : neg_q;
		ovf_e  = start ? 1'b0 : ovf_q;
		any_e  = start ? 1'b0 : any_q;
		cnt_e  = start ? '0 : cnt_q;
		cons_e = start ? '0 : cons_q;
		rdx_e  = start ? radix : rdx_q;
		wl_e   = start ? max_width : wl_q;
		uns_e  = start ? is_unsigned : uns_q;
	end

	// An auto radix that reaches the digits without a prefix is decimal
	assign rdx_dig = (rdx_e == RDX_AUTO) ? RDX_DEC : rdx_e;

	always_comb begin
		dig     = '0;
		dig_vld = 1'b0;
		if (char_in inside {[CH_ZERO:CH_NINE]}) begin
			dig     = 4'(char_in - CH_ZERO);
			dig_vld = 1'b1;
		end else if (rdx_dig == RDX_HEX && char_in inside {[CH_LA:CH_LF_]}) begin
			dig     = 4'(char_in - CH_LA + 8'd10);
			dig_vld = 1'b1;
		end else if (rdx_dig == RDX_HEX && char_in inside {[CH_UA:CH_UF]}) begin
			dig     = 4'(char_in - CH_UA + 8'd10);
			dig_vld = 1'b1;
		end
	end

	assign stat.is_ws     = char_in inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
	assign stat.is_sign   = (char_in == CH_PLUS) || (char_in == CH_MINUS);
	assign stat.is_minus  = (char_in == CH_MINUS);
	assign stat.is_zero   = (char_in == CH_ZERO);
	assign stat.is_x      = (char_in == CH_LX) || (char_in == CH_UX);
	assign stat.rdx_auto  = (rdx_e == RDX_AUTO);
	assign stat.rdx_hex   = (rdx_e == RDX_HEX);
	assign stat.dig_ok    = dig_vld && ({1'b0, dig} < rdx_dig);

	assign cnt_inc        = (cnt_e == '1) ? cnt_e : cnt_e + 1'b1;
	assign stat.width_hit = (wl_e != '0) && (cnt_inc >= wl_e);

	// acc*r + d above the limit is the same test as acc > (lim - d) / r
	assign prod    = 69'(acc_e) * 69'(rdx_dig);
	assign sum     = 70'(prod) + 70'(dig);
	assign lim     = uns_e ? {6'd0, {ValW{1'b1}}} : {7'd0, {(ValW-1){1'b1}}};
	assign ovf_now = (sum > lim);

	always_comb begin
		acc_n  = (cmd.digit && !ovf_e && !ovf_now) ? sum[ValW-1:0] : acc_e;
		ovf_n  = ovf_e || (cmd.digit && !ovf_e && ovf_now);
		neg_n  = neg_e || cmd.set_neg;
		any_n  = any_e || cmd.set_any;
		cnt_n  = cmd.take ? cnt_inc : cnt_e;
		cons_n = (cmd.take || cmd.ws) ? ((cons_e == '1) ? cons_e : cons_e + 1'b1) : cons_e;
		rdx_n  = rdx_e;
		if (cmd.rdx_oct) begin
			rdx_n = RDX_OCT;
		end else if (cmd.rdx_hex) begin
			rdx_n = RDX_HEX;
		end else if (cmd.digit) begin
			rdx_n = rdx_dig;
		end
	end

	assign smax = {1'b0, {(ValW-1){1'b1}}};

	always_comb begin
		res = '0;
		if (ovf_n) begin
			res.parsed_value = uns_e ? {ValW{1'b1}} : (neg_n ? ~smax : smax);
		end else begin
			res.parsed_value = neg_n ? (~acc_n + 1'b1) : acc_n;
		end
		res.matched         = any_n;
		res.this_char_taken = 1'b0;
		res.chars_used      = cons_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			neg_q  <= 1'b0;
			ovf_q  <= 1'b0;
			any_q  <= 1'b0;
			cnt_q  <= '0;
			cons_q <= '0;
			rdx_q  <= RDX_DEC;
			wl_q   <= '0;
			uns_q  <= 1'b0;
		end else if (en) begin
			acc_q  <= acc_n;
			neg_q  <= neg_n;
			ovf_q  <= ovf_n;
			any_q  <= any_n;
			cnt_q  <= cnt_n;
			cons_q <= cons_n;
			rdx_q  <= rdx_n;
			wl_q   <= wl_e;
			uns_q  <= uns_e;
		end
	end

endmodule

>>> hw/rtl/ascii_integer_parser_width_radix.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_width_radix
// Converts a character stream into 64-bit integers, scanf style: leading
// whitespace, optional sign, radix prefix, field width and saturation.
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload
//  ----------+-----------+---------------------------------------------------
//  s_*       | in        | one character plus conversion settings
//  m_*       | out       | value, match flag, taken flag, characters used
//
//  One character per cycle while the output is not stalled: each transfer is
//  decoded, checked and accumulated in the cycle it is accepted (64x5 multiply-add
//  and limit compare are combinational), so sustained rate is one item per clock.
//  A result is held in the output register until taken; the input keeps
//  accepting while the output is free or is being taken in the same cycle.
//  Reset (arst_n low) returns the parser to idle with no conversion running.
//  A character with start clear while idle is accepted and dropped.
//
module ascii_integer_parser_width_radix import aip_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] char_in, [23:8] max_width, [28:24] radix, [29] is_unsigned, [31:30] zero
	input  logic [31:0] s_tdata,
	// [0] start_req
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [63:0] parsed_value, [64] matched, [65] this_char_taken,
	// [81:66] chars_used, [87:82] zero
	output logic [87:0] m_tdata
);

	logic      accept;
	logic      emit;
	logic      taken;
	aip_cmd_t  cmd;
	aip_stat_t stat;
	aip_res_t  res;
	aip_res_t  res_ld;
	logic      m_tvalid_q;
	aip_res_t  res_q;

	// Input is free whenever the result register is empty or draining
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	aip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.start  (s_tuser[0]),
		.stat   (stat),
		.cmd    (cmd),
		.emit   (emit),
		.taken  (taken)
	);

	aip_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.start       (s_tuser[0]),
		.char_in     (s_tdata[7:0]),
		.max_width   (s_tdata[23:8]),
		.radix       (s_tdata[28:24]),
		.is_unsigned (s_tdata[29]),
		.cmd         (cmd),
		.stat        (stat),
		.res         (res)
	);

	// Merge the controller's taken flag into the datapath result
	always_comb begin
		res_ld                 = res;
		res_ld.this_char_taken = taken;
	end

	// Result register: load on a finishing transfer, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			res_q <= res_ld;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, res_q.chars_used, res_q.this_char_taken,
		res_q.matched, res_q.parsed_value};

	// A new result appears only after an accepted character
	a_emit_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without an accepted character");

	// Nothing matched means nothing accumulated
	a_unmatched_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[64]) |-> (m_tdata[63:0] == 64'd0))
		else $error("unmatched result carries a value");

	// A taken character is always counted in chars_used
	a_taken_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[65]) |-> (m_tdata[81:66] != 16'd0))
		else $error("taken character not counted");

endmodule
